@@ design/ssbsf_pkg.sv @@
// ----------------------------------------------------------------------------
// ssbsf_pkg
// Shared constants and functions of the subsampled block smoothing filter.
// ----------------------------------------------------------------------------
`default_nettype none
package ssbsf_pkg;
	localparam int unsigned BORDER = 4;
	localparam int unsigned KDIM   = 9;

	localparam logic [1:0] REG_TAP_ROW   = 2'd0;
	localparam logic [1:0] REG_TAP_COL   = 2'd1;
	localparam logic [1:0] REG_BLOCK_ROW = 2'd2;
	localparam logic [1:0] REG_BLOCK_COL = 2'd3;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	// log2 of the kernel weight, 0 weight flagged separately
	function automatic logic [3:0] kern_lg(input logic [3:0] x, input logic [3:0] y);
		logic [3:0] dx;
		logic [3:0] dy;
		dx = (x > 4'd4) ? x - 4'd4 : 4'd4 - x;
		dy = (y > 4'd4) ? y - 4'd4 : 4'd4 - y;
		kern_lg = 4'd7 - dx - dy;
	endfunction

	function automatic logic kern_zero(input logic [3:0] x, input logic [3:0] y);
		kern_zero = ((x == 4'd0) || (x == 4'd8)) && ((y == 4'd0) || (y == 4'd8));
	endfunction
endpackage
`default_nettype wire

@@ design/subsampled_block_smoothing_filter_unit.sv @@
// ----------------------------------------------------------------------------
// subsampled_block_smoothing_filter_unit
// Frame store with a subsampled 9x9 power-of-two smoothing read path.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready. func 0 writes pixel_value to the
// frame store at (pixel_row, pixel_col) and gives no result. func 1 reads the
// smoothed pixel and gives one result on out_valid/out_ready.
// A write leaves the unit idle; the next request is taken on the next edge.
// A read first walks the block anchors of both axes, one step per cycle.
// When a block covers the pixel it then fetches the sampled kernel taps
// through the frame store, one tap per cycle (81 for tap step 1, 9 for
// step 4), drains the read pipeline, runs a 24-step restoring divide and
// loads the output register. A border read instead makes one frame store
// read and passes that pixel on; an interior read that no block covers, or
// a read outside the frame, gives 0.
// The result sits in an output register; the next request is taken while it
// waits, and a later read is held in its last step until the result is taken.
// The configuration channel cfg_valid/cfg_ready writes the four step
// registers; it is always ready. A step of 0 acts as 1.
// Reset sets all steps to 4 and empties the output; the frame store content
// is undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none
module subsampled_block_smoothing_filter_unit
	import ssbsf_pkg::*;
#(
	parameter int unsigned IMG_ROWS = 256,
	parameter int unsigned IMG_COLS = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_ready,
	input  wire logic       func,
	input  wire logic [7:0] pixel_row,
	input  wire logic [7:0] pixel_col,
	input  wire logic [7:0] pixel_value,
	output      logic       out_valid,
	input  wire logic       out_ready,
	output      logic [7:0] smoothed_value,
	input  wire logic       cfg_valid,
	output      logic       cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [2:0] cfg_data
);
	localparam int unsigned RW = $clog2(IMG_ROWS);
	localparam int unsigned CW = $clog2(IMG_COLS);
	localparam int unsigned AW = RW + CW;
	localparam int unsigned SW = 24;
	localparam int unsigned QW = 16;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ANCH, ST_TAP, ST_LAST, ST_DIV, ST_BORD, ST_DONE
	} state_t;

	state_t state_q;
	logic [7:0] mem [0:(1 << AW) - 1];
	logic [7:0] rdata_s1;
	logic [AW-1:0] raddr;
	logic ren;

	logic [2:0] tr_q, tc_q, br_q, bc_q;
	logic [12:0] row_q, col_q;
	logic inside_q;
	logic [12:0] ar_q, ac_q;
	logic [3:0] x_q, y_q;
	logic [3:0] lg_s1;
	logic z_s1, acc_s1;
	logic [SW-1:0] sum_q;
	logic [QW-1:0] wsum_q;
	logic [SW-1:0] rem_q;
	logic [SW-1:0] quo_q;
	logic [4:0] cnt_q;
	logic [7:0] res_q;
	logic out_q;
	logic [12:0] ka_q, kc_q;

	wire [2:0] etr = (tr_q == 3'd0) ? 3'd1 : tr_q;
	wire [2:0] etc = (tc_q == 3'd0) ? 3'd1 : tc_q;
	wire [2:0] ebr = (br_q == 3'd0) ? 3'd1 : br_q;
	wire [2:0] ebc = (bc_q == 3'd0) ? 3'd1 : bc_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_q;
	assign smoothed_value = res_q;

	wire [12:0] r_lim = 13'(IMG_ROWS - BORDER);
	wire [12:0] c_lim = 13'(IMG_COLS - BORDER);
	wire [12:0] r_last = 13'(IMG_ROWS - 9 + BORDER);
	wire [12:0] c_last = 13'(IMG_COLS - 9 + BORDER);

	// anchor search: step k through anchors one per cycle
	wire [12:0] ka_n = ka_q + 13'(ebr);
	wire [12:0] kc_n = kc_q + 13'(ebc);
	wire ra_more = (ka_n <= row_q) && (ka_n <= r_last);
	wire ca_more = (kc_n <= col_q) && (kc_n <= c_last);

	wire [12:0] tap_r = ar_q - 13'(BORDER) + 13'(x_q);
	wire [12:0] tap_c = ac_q - 13'(BORDER) + 13'(y_q);
	wire [4:0] y_n = 5'(y_q) + 5'(etc);
	wire [4:0] x_n = 5'(x_q) + 5'(etr);
	wire tap_end = (y_n >= 5'd9) && (x_n >= 5'd9);

	wire [SW:0] trial = {rem_q[SW-1:0], quo_q[SW-1]} - (SW+1)'(wsum_q);

	always_comb begin
		ren = 1'b0;
		raddr = {row_q[RW-1:0], col_q[CW-1:0]};
		if (state_q == ST_TAP) begin
			ren = 1'b1;
			raddr = {tap_r[RW-1:0], tap_c[CW-1:0]};
		end else if (state_q == ST_BORD) begin
			ren = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && func == FUNC_WRITE &&
				{5'd0, pixel_row} < 13'(IMG_ROWS) && {5'd0, pixel_col} < 13'(IMG_COLS))
			mem[{pixel_row[RW-1:0], pixel_col[CW-1:0]}] <= pixel_value;
		if (ren)
			rdata_s1 <= mem[raddr];
		lg_s1  <= kern_lg(x_q, y_q);
		z_s1   <= kern_zero(x_q, y_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tr_q <= 3'd4; tc_q <= 3'd4; br_q <= 3'd4; bc_q <= 3'd4;
			out_q <= 1'b0;
			acc_s1 <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_TAP_ROW:   tr_q <= cfg_data;
					REG_TAP_COL:   tc_q <= cfg_data;
					REG_BLOCK_ROW: br_q <= cfg_data;
					REG_BLOCK_COL: bc_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_q && out_ready)
				out_q <= 1'b0;
			acc_s1 <= (state_q == ST_TAP);
			if (acc_s1 && !z_s1) begin
				sum_q  <= sum_q + (SW'(rdata_s1) << lg_s1);
				wsum_q <= wsum_q + (QW'(1) << lg_s1);
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready && func == FUNC_READ) begin
						row_q <= {5'd0, pixel_row};
						col_q <= {5'd0, pixel_col};
						inside_q <= {5'd0, pixel_row} < 13'(IMG_ROWS) &&
							{5'd0, pixel_col} < 13'(IMG_COLS);
						ka_q <= 13'(BORDER);
						kc_q <= 13'(BORDER);
						state_q <= ST_ANCH;
					end
				end
				ST_ANCH: begin
					if (ra_more) ka_q <= ka_n;
					if (ca_more) kc_q <= kc_n;
					if (!ra_more && !ca_more) begin
						x_q <= 4'd0; y_q <= 4'd0;
						sum_q <= '0; wsum_q <= '0;
						ar_q <= ka_q; ac_q <= kc_q;
						if (!inside_q) begin
							state_q <= ST_DONE;
						end else if (row_q >= 13'(BORDER) && col_q >= 13'(BORDER) &&
								row_q - ka_q <= 13'd3 && col_q - kc_q <= 13'd3) begin
							state_q <= ST_TAP;
						end else if (row_q < 13'(BORDER) || col_q < 13'(BORDER) ||
								row_q >= r_lim || col_q >= c_lim) begin
							state_q <= ST_BORD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_TAP: begin
					if (tap_end) begin
						state_q <= ST_LAST;
					end else if (y_n >= 5'd9) begin
						y_q <= 4'd0;
						x_q <= x_n[3:0];
					end else begin
						y_q <= y_n[3:0];
					end
				end
				ST_LAST: begin
					if (!acc_s1) begin
						rem_q <= '0;
						quo_q <= sum_q;
						cnt_q <= 5'd0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!trial[SW]) begin
						rem_q <= trial[SW-1:0];
						quo_q <= {quo_q[SW-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[SW-2:0], quo_q[SW-1]};
						quo_q <= {quo_q[SW-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(SW - 1)) state_q <= ST_DONE;
				end
				ST_BORD: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_q) begin
						out_q <= 1'b1;
						state_q <= ST_IDLE;
						if (ar_q != 13'd0 && row_q >= 13'(BORDER) && col_q >= 13'(BORDER)
								&& inside_q && row_q - ar_q <= 13'd3 && col_q - ac_q <= 13'd3)
							res_q <= (wsum_q == '0) ? 8'd0 : quo_q[7:0];
						else if (inside_q && (row_q < 13'(BORDER) || col_q < 13'(BORDER) ||
								row_q >= r_lim || col_q >= c_lim))
							res_q <= rdata_s1;
						else
							res_q <= 8'd0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ bench/ssbsf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbsf_checker
// Watches the request, result and step register channels of the smoothing
// filter, keeps its own copy of the frame and the steps, works out the
// smoothed value of every accepted read and compares it with the results in
// order. Reports its failure count and the number of results still due.
// ----------------------------------------------------------------------------
module ssbsf_checker
	import ssbsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic       func,
	input  logic [7:0] pixel_row,
	input  logic [7:0] pixel_col,
	input  logic [7:0] pixel_value,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] smoothed_value,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [2:0] cfg_data,
	output int         fail_count,
	output int         pending
);
	bit [7:0]   frame [256][256];
	logic [2:0] tap_row_step, tap_col_step, blk_row_step, blk_col_step;
	logic [7:0] smoothed_due [$];

	function automatic int unsigned step_of(logic [2:0] s);
		return (s == 3'd0) ? 1 : 32'(s);
	endfunction

	// covering anchor on one axis, -1 when no block covers the coordinate
	function automatic int block_anchor(int unsigned p, int unsigned s);
		int unsigned a;
		int unsigned last;
		if (p < BORDER) return -1;
		last = BORDER + ((256 - 9) / s) * s;
		a = BORDER + ((p - BORDER) / s) * s;
		if (a > last) a = last;
		if (p - a > 3) return -1;
		return a;
	endfunction

	function automatic logic [7:0] smoothed_pixel(int unsigned r, int unsigned c);
		int ar, ac, dx, dy;
		int unsigned tr, tc, w, acc, wtot;
		ar = block_anchor(r, step_of(blk_row_step));
		ac = block_anchor(c, step_of(blk_col_step));
		if (ar < 0 || ac < 0) begin
			if (r < BORDER || c < BORDER || r >= 256 - BORDER || c >= 256 - BORDER)
				return frame[r][c];
			return 8'd0;
		end
		tr = step_of(tap_row_step);
		tc = step_of(tap_col_step);
		acc = 0;
		wtot = 0;
		for (int x = 0; x < KDIM; x += tr) begin
			for (int y = 0; y < KDIM; y += tc) begin
				dx = (x > 4) ? x - 4 : 4 - x;
				dy = (y > 4) ? y - 4 : 4 - y;
				w = (1 << (8 - dx - dy)) >> 1;
				acc += frame[ar - 4 + x][ac - 4 + y] * w;
				wtot += w;
			end
		end
		if (wtot == 0) return 8'd0;
		return 8'(acc / wtot);
	endfunction

	assign pending = smoothed_due.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_row_step <= 3'd4;
			tap_col_step <= 3'd4;
			blk_row_step <= 3'd4;
			blk_col_step <= 3'd4;
			fail_count <= 0;
			smoothed_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TAP_ROW:   tap_row_step <= cfg_data;
					REG_TAP_COL:   tap_col_step <= cfg_data;
					REG_BLOCK_ROW: blk_row_step <= cfg_data;
					REG_BLOCK_COL: blk_col_step <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (smoothed_due.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %0d",
						$time, smoothed_value);
					fail_count <= fail_count + 1;
				end else begin
					if (smoothed_due[0] !== smoothed_value) begin
						$display("%0t: smoothed_value expected %0d actual %0d",
							$time, smoothed_due[0], smoothed_value);
						fail_count <= fail_count + 1;
					end
					void'(smoothed_due.pop_front());
				end
			end
			if (in_valid && in_ready) begin
				if (func == FUNC_WRITE)
					frame[pixel_row][pixel_col] = pixel_value;
				else
					smoothed_due.push_back(smoothed_pixel(pixel_row, pixel_col));
			end
		end
	end
endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixel writes, smoothed reads and step register writes into the
// smoothing filter through several step settings and idle patterns; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	import ssbsf_pkg::*;

	localparam int LIMIT = 1000000;

	logic       clk, arst_n;
	logic       in_valid, in_ready, func;
	logic [7:0] pixel_row, pixel_col, pixel_value;
	logic       out_valid, out_ready;
	logic [7:0] smoothed_value;
	logic       cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [2:0] cfg_data;
	int         fail_count, pending, cycles;
	int         send_idle, recv_stall;
	bit         written [256][256];

	subsampled_block_smoothing_filter_unit i_dut (.*);
	ssbsf_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		out_ready <= ($urandom_range(99) >= recv_stall);
		if (cycles >= LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	task automatic send_request(logic f, logic [7:0] r, logic [7:0] c, logic [7:0] v);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		pixel_row <= r;
		pixel_col <= c;
		pixel_value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (f == FUNC_WRITE) written[r][c] = 1'b1;
	endtask

	// writes every pixel a read at (r, c) could touch that is still unset
	task automatic read_pixel(int r, int c);
		for (int i = r - 7; i <= r + 4; i++)
			for (int j = c - 7; j <= c + 4; j++)
				if (i >= 0 && i < 256 && j >= 0 && j < 256 && !written[i][j])
					send_request(FUNC_WRITE, 8'(i), 8'(j), 8'($urandom_range(255)));
		send_request(FUNC_READ, 8'(r), 8'(c), 8'($urandom_range(255)));
	endtask

	task automatic write_step_reg(logic [1:0] idx, logic [2:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	initial begin
		logic [2:0] steps [4];
		int base, span, r, c;
		arst_n = 1'b0;
		cycles = 0;
		send_idle = 0;
		recv_stall = 0;
		in_valid <= 1'b0;
		func <= FUNC_WRITE;
		pixel_row <= 8'd0;
		pixel_col <= 8'd0;
		pixel_value <= 8'd0;
		out_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_TAP_ROW;
		cfg_data <= 3'd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of coordinates and values, corners, border and anchors
		send_request(FUNC_WRITE, 8'd0, 8'd0, 8'd255);
		send_request(FUNC_WRITE, 8'd255, 8'd255, 8'd0);
		send_request(FUNC_WRITE, 8'd0, 8'd255, 8'd170);
		send_request(FUNC_WRITE, 8'd255, 8'd0, 8'd85);
		read_pixel(0, 0);
		read_pixel(255, 255);
		read_pixel(0, 255);
		read_pixel(255, 0);
		read_pixel(4, 4);
		read_pixel(7, 7);
		read_pixel(3, 12);
		read_pixel(251, 251);
		read_pixel(247, 250);
		read_pixel(128, 127);
		send_request(FUNC_WRITE, 8'd4, 8'd4, 8'd255);
		read_pixel(4, 4);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: steps = '{3'd1, 3'd1, 3'd1, 3'd1};
				1: steps = '{3'd7, 3'd7, 3'd7, 3'd7};
				2: steps = '{3'd0, 3'd0, 3'd4, 3'd4};
				3: steps = '{3'd4, 3'd2, 3'd5, 3'd3};
				default:
					foreach (steps[i]) steps[i] = 3'($urandom_range(7));
			endcase
			write_step_reg(REG_TAP_ROW, steps[0]);
			write_step_reg(REG_TAP_COL, steps[1]);
			write_step_reg(REG_BLOCK_ROW, steps[2]);
			write_step_reg(REG_BLOCK_COL, steps[3]);
			cfg_valid <= 1'b0;
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 69; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 69; end
				default: begin send_idle = 9; recv_stall = 9; end
			endcase
			for (int n = 0; n < 20; n++) begin
				// top-left corner, bottom-right corner or a small interior patch
				case ($urandom_range(2))
					0: begin base = 0; span = 8; end
					1: begin base = 248; span = 8; end
					default: begin base = 126; span = 4; end
				endcase
				r = base + int'($urandom_range(span - 1));
				c = base + int'($urandom_range(span - 1));
				if ($urandom_range(99) < 40)
					send_request(FUNC_WRITE, 8'(r), 8'(c), 8'($urandom_range(255)));
				else
					read_pixel(r, c);
			end
			drain();
		end

		if (fail_count == 0 && pending == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule

@@ filelist.f @@
design/ssbsf_pkg.sv
design/subsampled_block_smoothing_filter_unit.sv
bench/ssbsf_checker.sv
bench/testbench.sv
